>>> rtl/skf_pkg.sv
`default_nettype none

package skf_pkg;

  // Width of the configuration register index on the write channel.
  localparam int unsigned CFG_IDX_W = 8;

  // Width of the gain field of a result.
  localparam int unsigned GAIN_W = 25;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_INIT_EST   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_VAR   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PROC_NOISE = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MEAS_NOISE = 8'd3;

  // Request from the sequencer to the divider.
  typedef struct packed {
    logic start;
  } div_ctrl_t;

  // Divider status back to the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

>>> rtl/skf_div.sv
`default_nettype none

// Restoring divider for the gain: floor(num * 2^F / den), with num <= den.
// One quotient bit per cycle after the start cycle.
module skf_div #(
  parameter int unsigned VAR_FRAC_BITS = 24
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire skf_pkg::div_ctrl_t ctrl_i,
  input  wire  [31:0]             num_i,
  input  wire  [32:0]             den_i,
  output skf_pkg::div_stat_t      stat_o,
  output logic [VAR_FRAC_BITS:0]  quo_o
);

  localparam int unsigned F  = VAR_FRAC_BITS;
  localparam int unsigned CW = $clog2(F + 1);
  localparam logic [F:0]  ONE = {1'b1, {F{1'b0}}};

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [32:0]   rem_q, rem_d;
  logic [32:0]   den_q, den_d;
  logic [F:0]    quo_q, quo_d;

  logic [33:0]   rem2;
  logic          fits;

  // One restoring step: double the remainder and subtract if it fits.
  assign rem2 = {rem_q, 1'b0};
  assign fits = rem2 >= {1'b0, den_q};

  // Control and datapath next values.
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    if (ctrl_i.start) begin
      den_d = den_i;
      rem_d = {1'b0, num_i};
      quo_d = '0;
      cnt_d = CW'(F);
      if (den_i == 33'd0) begin
        // Both variances are zero: the gain is defined as zero.
        done_d = 1'b1;
        busy_d = 1'b0;
      end else if (den_i == {1'b0, num_i}) begin
        // No measurement noise: the gain is exactly one.
        quo_d  = ONE;
        done_d = 1'b1;
        busy_d = 1'b0;
      end else begin
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      rem_d = fits ? 33'(rem2 - {1'b0, den_q}) : rem2[32:0];
      quo_d = {quo_q[F-1:0], fits};
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quo_o       = quo_q;

endmodule

`default_nettype wire

>>> rtl/scalar_kalman_filter.sv
// Sequencing: an input transfer steps through the prep, start, wait, first multiply,
// second multiply and finish states; the wait state holds for the bit-per-cycle gain
// divider, which is skipped (no measurement noise, or prior and measurement noise both zero).
// One item at a time: the next item is taken once the result sits in the output
// register; the finish state holds while a held result is stalled.
// Reset: asynchronous, active low; estimate and variance load the reset values.
`default_nettype none

module scalar_kalman_filter #(
  parameter int unsigned VAR_FRAC_BITS = 24
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  // Input channel.
  input  wire                              in_valid_i,
  output logic                             in_stall_o,
  input  wire  [15:0]                      measurement_i,
  // Output channel.
  output logic                             out_valid_o,
  input  wire                              out_stall_i,
  output logic [31:0]                      estimate_o,
  output logic [skf_pkg::GAIN_W-1:0]       gain_o,
  output logic [31:0]                      variance_o,
  // Configuration write channel.
  input  wire                              cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire  [skf_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire  [31:0]                      cfg_data_i
);

  localparam int unsigned F  = VAR_FRAC_BITS;
  localparam int unsigned GW = F + 1;
  localparam int unsigned PW = 32 + GW;

  localparam logic [GW-1:0] ONE  = {1'b1, {F{1'b0}}};
  localparam logic [PW-1:0] HALF = {{(PW - F){1'b0}}, 1'b1, {(F - 1){1'b0}}};

  // Register reset values.
  localparam logic [31:0] RST_INIT_EST   = 32'd0;
  localparam logic [31:0] RST_INIT_VAR   = 32'(64'd1 << F);
  localparam logic [31:0] RST_PROC_NOISE = 32'(((64'd1 << F) + 64'd500) / 64'd1000);
  localparam logic [31:0] RST_MEAS_NOISE = 32'(((64'd1 << F) + 64'd5) / 64'd10);

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PREP  = 3'd1;
  localparam logic [2:0] S_START = 3'd2;
  localparam logic [2:0] S_WAIT  = 3'd3;
  localparam logic [2:0] S_MUL1  = 3'd4;
  localparam logic [2:0] S_MUL2  = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0]    state_q, state_d;

  logic [31:0]   init_est_q, init_est_d;
  logic [31:0]   init_var_q, init_var_d;
  logic [31:0]   pn_q, pn_d;
  logic [31:0]   mn_q, mn_d;
  logic          reload;
  logic          cfg_we;

  logic [31:0]   est_q;
  logic [31:0]   var_q;
  logic [15:0]   meas_q;
  logic [31:0]   prior_q;
  logic [32:0]   den_q;
  logic [31:0]   mag_q;
  logic          up_q;
  logic [GW-1:0] gain_q;
  logic [PW-1:0] prod_q;

  logic          out_valid_q;
  logic [31:0]   out_est_q;
  logic [GW-1:0] out_gain_q;
  logic [31:0]   out_var_q;

  logic          in_xfer;
  logic          fin_go;

  logic [32:0]   psum;
  logic [31:0]   prior_c;
  logic [32:0]   den_c;
  logic [31:0]   target;
  logic          up_c;
  logic [31:0]   mag_c;

  logic [31:0]   mul_a;
  logic [GW-1:0] mul_b;
  logic [PW-1:0] rnd;
  logic [32:0]   rsh;
  logic [31:0]   delta;
  logic [31:0]   est_new;
  logic [31:0]   post;

  logic [GW+skf_pkg::GAIN_W-1:0] gain_ext;

  skf_pkg::div_ctrl_t div_ctrl;
  skf_pkg::div_stat_t div_stat;
  logic [F:0]         div_quo;

  // Handshakes.
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = (state_q == S_IDLE);
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign fin_go      = (state_q == S_FIN) && (!out_valid_q || !out_stall_i);

  // Configuration register writes; a valid index reloads the filter state.
  always_comb begin
    init_est_d = init_est_q;
    init_var_d = init_var_q;
    pn_d       = pn_q;
    mn_d       = mn_q;
    reload     = 1'b0;
    if (cfg_we) begin
      unique case (cfg_index_i)
        skf_pkg::REG_INIT_EST: begin
          init_est_d = cfg_data_i;
          reload     = 1'b1;
        end
        skf_pkg::REG_INIT_VAR: begin
          init_var_d = cfg_data_i;
          reload     = 1'b1;
        end
        skf_pkg::REG_PROC_NOISE: begin
          pn_d   = cfg_data_i;
          reload = 1'b1;
        end
        skf_pkg::REG_MEAS_NOISE: begin
          mn_d   = cfg_data_i;
          reload = 1'b1;
        end
        default: begin
          reload = 1'b0;
        end
      endcase
    end
  end

  // Prior variance with saturation, denominator and innovation magnitude.
  assign psum    = {1'b0, var_q} + {1'b0, pn_q};
  assign prior_c = psum[32] ? 32'hFFFF_FFFF : psum[31:0];
  assign den_c   = {1'b0, prior_c} + {1'b0, mn_q};
  assign target  = {meas_q, 16'd0};
  assign up_c    = target >= est_q;
  assign mag_c   = up_c ? (target - est_q) : (est_q - target);

  // Shared multiplier: gain times innovation, then (1 - gain) times prior.
  assign mul_a = (state_q == S_MUL1) ? mag_q  : prior_q;
  assign mul_b = (state_q == S_MUL1) ? gain_q : (ONE - gain_q);

  // Round to nearest, drop the fraction and clamp.
  assign rnd     = prod_q + HALF;
  assign rsh     = rnd[PW-1:F];
  assign delta   = (rsh > {1'b0, mag_q})   ? mag_q   : rsh[31:0];
  assign post    = (rsh > {1'b0, prior_q}) ? prior_q : rsh[31:0];
  assign est_new = up_q ? (est_q + delta) : (est_q - delta);

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_xfer) begin
        state_d = S_PREP;
      end
      S_PREP:  state_d = S_START;
      S_START: state_d = S_WAIT;
      S_WAIT:  if (div_stat.done && !div_stat.busy) begin
        state_d = S_MUL1;
      end
      S_MUL1:  state_d = S_MUL2;
      S_MUL2:  state_d = S_FIN;
      S_FIN:   if (fin_go) begin
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign div_ctrl.start = (state_q == S_START);

  skf_div #(
    .VAR_FRAC_BITS(VAR_FRAC_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (div_ctrl),
    .num_i  (prior_q),
    .den_i  (den_q),
    .stat_o (div_stat),
    .quo_o  (div_quo)
  );

  // Control, configuration and filter state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      init_est_q  <= RST_INIT_EST;
      init_var_q  <= RST_INIT_VAR;
      pn_q        <= RST_PROC_NOISE;
      mn_q        <= RST_MEAS_NOISE;
      est_q       <= RST_INIT_EST;
      var_q       <= RST_INIT_VAR;
    end else begin
      state_q    <= state_d;
      init_est_q <= init_est_d;
      init_var_q <= init_var_d;
      pn_q       <= pn_d;
      mn_q       <= mn_d;
      if (fin_go) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (reload) begin
        est_q <= init_est_d;
      end else if (state_q == S_MUL2) begin
        est_q <= est_new;
      end
      if (reload) begin
        var_q <= init_var_d;
      end else if (fin_go) begin
        var_q <= post;
      end
    end
  end

  // Datapath and output payload registers.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      meas_q <= measurement_i;
    end
    if (state_q == S_PREP) begin
      prior_q <= prior_c;
      den_q   <= den_c;
      mag_q   <= mag_c;
      up_q    <= up_c;
    end
    if (state_q == S_WAIT) begin
      gain_q <= div_quo;
    end
    if (state_q == S_MUL1 || state_q == S_MUL2) begin
      prod_q <= {{GW{1'b0}}, mul_a} * {{32{1'b0}}, mul_b};
    end
    if (fin_go) begin
      out_est_q  <= est_q;
      out_gain_q <= gain_q;
      out_var_q  <= post;
    end
  end

  // The gain field shows the low bits of the gain.
  assign gain_ext    = {{skf_pkg::GAIN_W{1'b0}}, out_gain_q};
  assign out_valid_o = out_valid_q;
  assign estimate_o  = out_est_q;
  assign gain_o      = gain_ext[skf_pkg::GAIN_W-1:0];
  assign variance_o  = out_var_q;

`ifndef ASSERT_OFF
  // An accepted item holds off the next one.
  a_stall_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> in_stall_o)
    else $error("input not stalled after a transfer");

  // The divider reports completion only while the sequencer waits for it.
  a_div_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == S_WAIT))
    else $error("divider done outside the wait state");

  // The gain never exceeds one.
  a_gain_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL1) |-> (gain_q <= ONE))
    else $error("gain above one");

  // The posterior variance never exceeds the prior.
  a_post_le_prior: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_go |=> (var_q <= prior_q))
    else $error("posterior variance above prior");
`endif

endmodule

`default_nettype wire

>>> tb/skf_result_checker.sv
// Watches the three channels of the scalar Kalman filter, keeps its own copy of
// the filter state and configuration, and compares every result transfer with
// the oldest predicted result.
module skf_result_checker #(
  parameter int unsigned FRAC_W = 24
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           in_valid_i,
  input  wire                           in_stall_i,
  input  wire [15:0]                    measurement_i,
  input  wire                           out_valid_i,
  input  wire                           out_stall_i,
  input  wire [31:0]                    estimate_i,
  input  wire [skf_pkg::GAIN_W-1:0]     gain_i,
  input  wire [31:0]                    variance_i,
  input  wire                           cfg_valid_i,
  input  wire                           cfg_ready_i,
  input  wire [skf_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire [31:0]                    cfg_data_i,
  output int                            errors_o,
  output int                            pending_o
);

  typedef struct packed {
    logic [31:0]                estimate;
    logic [skf_pkg::GAIN_W-1:0] gain;
    logic [31:0]                variance;
  } filter_result_t;

  localparam logic [63:0] ONE = 64'd1 << FRAC_W;
  localparam logic [63:0] MAX32 = 64'hFFFF_FFFF;

  // Configuration copy and filter state.
  logic [31:0] start_estimate;
  logic [31:0] start_variance;
  logic [31:0] proc_noise;
  logic [31:0] measurement_noise;
  logic [31:0] estimate_now;
  logic [31:0] variance_now;

  filter_result_t expected_results[$];

  // One measurement update: prior, gain, estimate move and posterior variance.
  function automatic filter_result_t filter_step(
    input logic [15:0] meas,
    input logic [31:0] est,
    input logic [31:0] variance_in,
    input logic [31:0] q_noise,
    input logic [31:0] r_noise
  );
    logic [63:0] prior;
    logic [63:0] den;
    logic [63:0] k;
    logic [63:0] target;
    logic [63:0] mag;
    logic [63:0] delta;
    logic [63:0] post;
    logic [63:0] next_est;
    logic        up;
    filter_result_t res;
    prior = {32'd0, variance_in} + {32'd0, q_noise};
    if (prior > MAX32) begin
      prior = MAX32;
    end
    den = prior + {32'd0, r_noise};
    if (den == 64'd0) begin
      k = 64'd0;
    end else begin
      k = (prior << FRAC_W) / den;
    end
    if (k > ONE) begin
      k = ONE;
    end
    target = {32'd0, meas, 16'd0};
    up = target >= {32'd0, est};
    mag = up ? (target - {32'd0, est}) : ({32'd0, est} - target);
    // Round to nearest, ties away from zero, applied to the magnitude.
    delta = (mag * k + (ONE >> 1)) >> FRAC_W;
    if (delta > mag) begin
      delta = mag;
    end
    next_est = up ? ({32'd0, est} + delta) : ({32'd0, est} - delta);
    post = ((ONE - k) * prior + (ONE >> 1)) >> FRAC_W;
    if (post > prior) begin
      post = prior;
    end
    res.estimate = next_est[31:0];
    res.gain     = k[skf_pkg::GAIN_W-1:0];
    res.variance = post[31:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    filter_result_t exp_res;
    filter_result_t next_res;
    logic           reload;
    int             err_cnt;
    if (!rst_ni) begin
      start_estimate    <= 32'd0;
      start_variance    <= 32'd1 << FRAC_W;
      proc_noise        <= 32'(((64'd1 << FRAC_W) + 64'd500) / 64'd1000);
      measurement_noise <= 32'(((64'd1 << FRAC_W) + 64'd5) / 64'd10);
      estimate_now      <= 32'd0;
      variance_now      <= 32'd1 << FRAC_W;
      expected_results.delete();
      errors_o          <= 0;
      pending_o         <= 0;
    end else begin
      err_cnt = errors_o;

      // Result transfer: compare with the oldest prediction.
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result: expected none, got estimate %h gain %h variance %h",
                   $time, estimate_i, gain_i, variance_i);
          err_cnt++;
        end else begin
          exp_res = expected_results.pop_front();
          if (estimate_i !== exp_res.estimate) begin
            $display("%0t: estimate mismatch: expected %h, got %h",
                     $time, exp_res.estimate, estimate_i);
            err_cnt++;
          end
          if (gain_i !== exp_res.gain) begin
            $display("%0t: gain mismatch: expected %h, got %h", $time, exp_res.gain, gain_i);
            err_cnt++;
          end
          if (variance_i !== exp_res.variance) begin
            $display("%0t: variance mismatch: expected %h, got %h",
                     $time, exp_res.variance, variance_i);
            err_cnt++;
          end
        end
      end

      // Measurement transfer: predict the result and advance the state.
      if (in_valid_i && !in_stall_i) begin
        next_res = filter_step(measurement_i, estimate_now, variance_now,
                               proc_noise, measurement_noise);
        expected_results.push_back(next_res);
        estimate_now <= next_res.estimate;
        variance_now <= next_res.variance;
      end

      // Register write: store and reload the state; unknown indexes are ignored.
      if (cfg_valid_i && cfg_ready_i) begin
        reload = 1'b1;
        case (cfg_index_i)
          skf_pkg::REG_INIT_EST:   start_estimate    <= cfg_data_i;
          skf_pkg::REG_INIT_VAR:   start_variance    <= cfg_data_i;
          skf_pkg::REG_PROC_NOISE: proc_noise        <= cfg_data_i;
          skf_pkg::REG_MEAS_NOISE: measurement_noise <= cfg_data_i;
          default:                 reload = 1'b0;
        endcase
        if (reload) begin
          estimate_now <= (cfg_index_i == skf_pkg::REG_INIT_EST) ? cfg_data_i : start_estimate;
          variance_now <= (cfg_index_i == skf_pkg::REG_INIT_VAR) ? cfg_data_i : start_variance;
        end
      end

      errors_o  <= err_cnt;
      pending_o <= expected_results.size();
    end
  end

endmodule

>>> tb/tb_scalar_kalman_filter.sv
module tb_scalar_kalman_filter;

  localparam int unsigned FRAC_W = 24;
  localparam int unsigned IDX_W = skf_pkg::CFG_IDX_W;
  localparam int unsigned NUM_REGS = 4;
  localparam int unsigned SETTLE_CYCLES = FRAC_W + 16;
  localparam int unsigned RANDOM_ITEMS = 1250;
  localparam longint unsigned CYCLE_LIMIT = 1_000_000;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_e;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_stall_o;
  logic [15:0]                 measurement = 16'd0;
  logic                        out_valid_o;
  logic                        out_stall = 1'b0;
  logic [31:0]                 estimate_o;
  logic [skf_pkg::GAIN_W-1:0]  gain_o;
  logic [31:0]                 variance_o;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready_o;
  logic [IDX_W-1:0]            cfg_index = '0;
  logic [31:0]                 cfg_data = 32'd0;

  int                    check_errors;
  int                    pending;
  int                    burst_left = 0;
  int                    items_sent = 0;
  longint unsigned       cycle_count = 0;
  stall_mode_e           stall_mode = STALL_NONE;
  int                    stall_mode_left = 0;

  scalar_kalman_filter #(
    .VAR_FRAC_BITS(FRAC_W)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall_o),
    .measurement_i(measurement),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall),
    .estimate_o   (estimate_o),
    .gain_o       (gain_o),
    .variance_o   (variance_o),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  skf_result_checker #(
    .FRAC_W(FRAC_W)
  ) checker_inst (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall_o),
    .measurement_i(measurement),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall),
    .estimate_i   (estimate_o),
    .gain_i       (gain_o),
    .variance_i   (variance_o),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .errors_o     (check_errors),
    .pending_o    (pending)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Cycle counter with a hard limit on the run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Result side: the stall pattern switches at random between none, light, heavy and periodic modes.
  always @(posedge clk_i) begin
    if (stall_mode_left == 0) begin
      stall_mode      <= stall_mode_e'($urandom_range(0, 3));
      stall_mode_left <= $urandom_range(50, 400);
    end else begin
      stall_mode_left <= stall_mode_left - 1;
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= (cycle_count[4:0] < 5'd12);
    endcase
  end

  // Sends one measurement, opening a new burst after a random gap when the
  // current one is used up.
  task automatic send_measurement(input logic [15:0] value);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid    <= 1'b1;
    measurement <= value;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  // Holds the sender until every predicted result has come out, then optionally lets the filter settle.
  task automatic wait_for_results(input bit settle);
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    if (settle) begin
      repeat (SETTLE_CYCLES) @(posedge clk_i);
    end
  endtask

  task automatic write_register(input logic [IDX_W-1:0] index, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Writes all four registers once the filter is idle.
  task automatic configure(input logic [31:0] est0, input logic [31:0] var0,
                           input logic [31:0] q_noise, input logic [31:0] r_noise);
    wait_for_results(1'b1);
    write_register(skf_pkg::REG_INIT_EST, est0);
    write_register(skf_pkg::REG_INIT_VAR, var0);
    write_register(skf_pkg::REG_PROC_NOISE, q_noise);
    write_register(skf_pkg::REG_MEAS_NOISE, r_noise);
  endtask

  // Variance-like values: extremes, small values, values around 1.0 and fully random words.
  function automatic logic [31:0] pick_variance();
    case ($urandom_range(0, 5))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom;
      3:       return $urandom_range(0, 1 << 25);
      4:       return $urandom_range(0, 4096);
      default: return $urandom_range(1 << 20, 1 << 28);
    endcase
  endfunction

  function automatic logic [31:0] pick_estimate();
    case ($urandom_range(0, 3))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2:       return {16'($urandom_range(0, 65535)), 16'd0};
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick_measurement();
    case ($urandom_range(0, 9))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(0, 200));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  initial begin
    int phase_items;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset configuration, extremes of the measurement.
    send_measurement(16'd0);
    send_measurement(16'hFFFF);
    send_measurement(16'd0);
    send_measurement(16'd1);
    send_measurement(16'h8000);

    // Everything at its maximum: the prior saturates and the sum of prior and
    // measurement noise needs the extra bit.
    configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_measurement(16'd0);
    send_measurement(16'hFFFF);

    // Zero prior and zero measurement noise: the gain is zero and nothing moves.
    configure(32'h1234_5678, 32'd0, 32'd0, 32'd0);
    send_measurement(16'd100);
    send_measurement(16'hFFFF);

    // No measurement noise with a nonzero prior: the gain is exactly one.
    configure(32'd0, 32'd0, 32'd1, 32'd0);
    send_measurement(16'hFFFF);
    send_measurement(16'd0);

    // A write to an unknown index must neither store nor reload.
    configure(32'h0000_8000, 32'h0100_0000, 32'd16777, 32'd1677722);
    send_measurement(16'd1);
    wait_for_results(1'b1);
    write_register(IDX_W'(NUM_REGS), 32'hFFFF_FFFF);
    write_register({IDX_W{1'b1}}, 32'h0000_0000);
    send_measurement(16'd2);
    send_measurement(16'd3);

    // Random phases, each with a fresh configuration.
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      configure(pick_estimate(), pick_variance(), pick_variance(), pick_variance());
      if ($urandom_range(0, 3) == 0) begin
        write_register(IDX_W'($urandom_range(NUM_REGS, (1 << IDX_W) - 1)), $urandom);
      end
      phase_items = $urandom_range(40, 150);
      repeat (phase_items) begin
        if ($urandom_range(0, 199) == 0) begin
          wait_for_results(1'b0);
        end
        send_measurement(pick_measurement());
      end
    end

    wait_for_results(1'b1);
    if (check_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/skf_pkg.sv
rtl/skf_div.sv
rtl/scalar_kalman_filter.sv
tb/skf_result_checker.sv
tb/tb_scalar_kalman_filter.sv
